// ===== rtl/fca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed chunk allocator package
// Pool geometry, status codes and the request and response transfer types.
// ----------------------------------------------------------------------------
package fca_pkg;

	// Pool geometry.
	localparam int NUM_CHUNKS   = 1024;
	localparam int CHUNK_BYTES  = 128;
	localparam int CHUNK_STRIDE = 144;

	// Field widths.
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 32;

	// Request opcodes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Response status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SIZE    = 2'd1;
	localparam logic [1:0] ST_NOMEM   = 2'd2;
	localparam logic [1:0] ST_NOTUSED = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [SIZE_W-1:0] request_size;
		logic [IDX_W-1:0]  chunk_index;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [IDX_W-1:0]  granted_index;
		logic [ADDR_W-1:0] granted_address;
		logic [CNT_W-1:0]  free_count;
	} rsp_t;

endpackage

// ===== rtl/fixed_chunk_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed chunk allocator
// Free-list allocator for a pool of equal chunks kept in a FIFO free queue.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_* valid/ready channel, one response per request
//   leaves on the out_* valid/ready channel, in order. An allocate pops the
//   head of the free queue and returns the chunk index and its byte address;
//   a free pushes the named chunk at the tail if it is currently in use.
//   The pool base address is written through cfg_wr_en/cfg_wr_data while idle.
// Timing:
//   A request is accepted and the free queue and in-use memories are read in
//   that cycle; the next cycle, unless a held response stalls it, the result
//   is computed, written back and loaded into the output register, which
//   drives out_valid. A new request is taken only after the last one retires,
//   since each request does a read-modify-write of the single-port memories.
// Reset:
//   arst_n returns the pool to all chunks free in ascending order. Memory
//   contents are not cleared; fill counters tell which entries are live, so
//   no clearing pass is needed and requests are taken right after reset.
// Backpressure:
//   While out_ready is low the finished response holds, the pending request
//   waits in its stage and in_ready stays low until it can retire.
// ----------------------------------------------------------------------------
module fixed_chunk_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [fca_pkg::ADDR_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  fca_pkg::req_t             in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output fca_pkg::rsp_t             out_data
);
	import fca_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_CHUNKS);
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_CHUNKS - 1);

	// Storage.
	logic [IDX_W-1:0] queue_mem [NUM_CHUNKS];
	logic             mark_mem  [NUM_CHUNKS];

	// Control state.
	logic              busy_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  written_q;
	logic [CNT_W-1:0]  seen_q;
	logic [ADDR_W-1:0] pool_base_q;

	// Stage and read data.
	req_t             req_s1;
	logic [IDX_W-1:0] q_rdata_q;
	logic             mark_rdata_q;
	rsp_t             out_data_q;

	// Datapath.
	logic             accept;
	logic             done;
	logic             pop_fresh;
	logic [IDX_W-1:0] pop_idx;
	logic             size_bad;
	logic             in_use;
	logic             alloc_ok;
	logic             free_ok;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] tail_next;
	rsp_t             rsp;

	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign done      = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A queue position not yet written since reset still holds its own index.
	assign pop_fresh = {1'b0, head_q} >= written_q;
	assign pop_idx   = pop_fresh ? head_q : q_rdata_q;

	// Chunks beyond the allocation high-water mark were never marked in use.
	assign in_use = ({1'b0, req_s1.chunk_index} < seen_q) && mark_rdata_q;

	assign size_bad = (req_s1.request_size == '0) ||
		(req_s1.request_size > SIZE_W'(CHUNK_BYTES));

	assign alloc_ok = (req_s1.opcode == OP_ALLOC) && !size_bad && (count_q != '0);
	assign free_ok  = (req_s1.opcode == OP_FREE) && in_use &&
		({1'b0, req_s1.chunk_index} < FULL_CNT) && (count_q < FULL_CNT);

	assign head_next = (head_q == LAST_POS) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;

	// Response formation.
	always_comb begin
		rsp = '0;
		if (req_s1.opcode == OP_ALLOC) begin
			if (size_bad) begin
				rsp.status = ST_SIZE;
				rsp.free_count = count_q;
			end else if (count_q == '0) begin
				rsp.status = ST_NOMEM;
				rsp.free_count = count_q;
			end else begin
				rsp.status = ST_OK;
				rsp.granted_index = pop_idx;
				rsp.granted_address = pool_base_q +
					ADDR_W'(pop_idx) * ADDR_W'(CHUNK_STRIDE);
				rsp.free_count = count_q - 1'b1;
			end
		end else begin
			if (free_ok) begin
				rsp.status = ST_OK;
				rsp.granted_index = req_s1.chunk_index;
				rsp.free_count = count_q + 1'b1;
			end else begin
				rsp.status = ST_NOTUSED;
				rsp.free_count = count_q;
			end
		end
	end

	// Control registers and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= FULL_CNT;
			written_q   <= '0;
			seen_q      <= '0;
			pool_base_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				pool_base_q <= cfg_wr_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (done && alloc_ok) begin
				head_q  <= head_next;
				count_q <= count_q - 1'b1;
				if (pop_fresh) begin
					seen_q <= {1'b0, head_q} + 1'b1;
				end
			end
			if (done && free_ok) begin
				tail_q  <= tail_next;
				count_q <= count_q + 1'b1;
				if (written_q != FULL_CNT) begin
					written_q <= written_q + 1'b1;
				end
			end
		end
	end

	// Request stage and output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_data;
		end
		if (done) begin
			out_data_q <= rsp;
		end
	end

	// Free queue memory: read the head on accept, write the tail on a free.
	always_ff @(posedge clk) begin
		if (accept) begin
			q_rdata_q <= queue_mem[head_q];
		end
		if (done && free_ok) begin
			queue_mem[tail_q] <= req_s1.chunk_index;
		end
	end

	// In-use mark memory: read the named chunk on accept, update on success.
	always_ff @(posedge clk) begin
		if (accept) begin
			mark_rdata_q <= mark_mem[in_data.chunk_index];
		end
		if (done && alloc_ok) begin
			mark_mem[pop_idx] <= 1'b1;
		end else if (done && free_ok) begin
			mark_mem[req_s1.chunk_index] <= 1'b0;
		end
	end

endmodule

// ===== test/tb_fixed_chunk_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed chunk allocator testbench
// Sends allocate and free requests through the valid/ready request channel,
// predicts every response with a software copy of the free queue and in-use
// marks, and compares each response field by field in order. The pool is
// drained into out of memory and refilled under several pool base settings,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_fixed_chunk_allocator;
	import fca_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_SHOWN   = 10;

	// Software copy of the pool; it predicts and checks responses in order.
	class chunk_pool_model;
		logic [IDX_W-1:0]  ring [NUM_CHUNKS];
		bit                busy [NUM_CHUNKS];
		int unsigned       head;
		int unsigned       tail;
		int unsigned       avail;
		logic [ADDR_W-1:0] base;
		rsp_t              pending_rsp [$];
		int                mismatches;
		int                checked;
		int                status_seen [4];

		function new();
			for (int i = 0; i < NUM_CHUNKS; i++) begin
				ring[i] = IDX_W'(i);
				busy[i] = 1'b0;
			end
			head   = 0;
			tail   = 0;
			avail  = NUM_CHUNKS;
			base   = '0;
			mismatches = 0;
			checked    = 0;
			for (int s = 0; s < 4; s++) status_seen[s] = 0;
		endfunction

		// Apply one accepted request to the pool and queue its response.
		function void note_request(req_t r);
			rsp_t             e;
			logic [IDX_W-1:0] idx;
			e        = '0;
			e.status = ST_OK;
			if (r.opcode == OP_ALLOC) begin
				if (r.request_size == '0 || r.request_size > SIZE_W'(CHUNK_BYTES)) begin
					e.status = ST_SIZE;
				end else if (avail == 0) begin
					e.status = ST_NOMEM;
				end else begin
					idx   = ring[head];
					head  = (head + 1) % NUM_CHUNKS;
					avail = avail - 1;
					busy[idx] = 1'b1;
					e.granted_index   = idx;
					e.granted_address = base + ADDR_W'(idx) * ADDR_W'(CHUNK_STRIDE);
				end
			end else begin
				if (!busy[r.chunk_index] || avail >= NUM_CHUNKS) begin
					e.status = ST_NOTUSED;
				end else begin
					busy[r.chunk_index] = 1'b0;
					ring[tail] = r.chunk_index;
					tail  = (tail + 1) % NUM_CHUNKS;
					avail = avail + 1;
					e.granted_index = r.chunk_index;
				end
			end
			e.free_count = CNT_W'(avail);
			status_seen[e.status] = status_seen[e.status] + 1;
			pending_rsp.push_back(e);
		endfunction

		// Compare one response transfer with the oldest prediction.
		function void check_response(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: response with nothing pending: status %0d index %0d",
						$time, got.status, got.granted_index);
				return;
			end
			e       = pending_rsp.pop_front();
			checked = checked + 1;
			if (got.status !== e.status || got.granted_index !== e.granted_index ||
			    got.granted_address !== e.granted_address ||
			    got.free_count !== e.free_count) begin
				mismatches = mismatches + 1;
				if (mismatches <= MAX_SHOWN) begin
					$display("%0t: response %0d expected st %0d idx %0d addr %h free %0d",
						$time, checked, e.status, e.granted_index, e.granted_address,
						e.free_count);
					$display("%0t: response %0d got      st %0d idx %0d addr %h free %0d",
						$time, checked, got.status, got.granted_index,
						got.granted_address, got.free_count);
				end
			end
		endfunction

		// Return some chunk that is currently in use, or -1 if none is.
		function int pick_busy();
			int start;
			start = $urandom_range(0, NUM_CHUNKS - 1);
			for (int k = 0; k < NUM_CHUNKS; k++) begin
				if (busy[(start + k) % NUM_CHUNKS])
					return (start + k) % NUM_CHUNKS;
			end
			return -1;
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [ADDR_W-1:0] cfg_wr_data;
	logic              in_valid;
	logic              in_ready;
	req_t              in_data;
	logic              out_valid;
	logic              out_ready;
	rsp_t              out_data;

	chunk_pool_model pool;
	int              sent_n;
	int              cycles;
	int              stall_left;
	int              base_writes;

	fixed_chunk_allocator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_fixed_chunk_allocator: errors");
			$finish;
		end
	end

	// Response side: check each transfer, then hold out_ready low at random.
	// Every 300 responses, the first 60 go through with no stall.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			pool.check_response(out_data);
			stall_left = ((pool.checked % 300) < 60) ? 0 : $urandom_range(0, 18);
			out_ready <= (stall_left == 0);
		end else if (!out_ready) begin
			if (stall_left > 0)
				stall_left = stall_left - 1;
			if (stall_left == 0)
				out_ready <= 1'b1;
		end
	end

	function automatic req_t make_req(logic op, logic [SIZE_W-1:0] size,
	                                   logic [IDX_W-1:0] idx);
		req_t r;
		r.opcode       = op;
		r.request_size = size;
		r.chunk_index  = idx;
		return r;
	endfunction

	// Random request; allocates mostly ask a legal size, frees mostly name a live chunk.
	function automatic req_t random_request(int alloc_pct);
		req_t r;
		int   pick;
		int   live;
		r.opcode       = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
		r.request_size = $urandom();
		r.chunk_index  = IDX_W'($urandom());
		if (r.opcode == OP_ALLOC) begin
			pick = $urandom_range(0, 19);
			if (pick < 17)
				r.request_size = $urandom_range(1, CHUNK_BYTES);
			else if (pick == 17)
				r.request_size = '0;
			else if (pick == 18)
				r.request_size = $urandom_range(32'hFFFF_FFFF, CHUNK_BYTES + 1);
		end else if ($urandom_range(0, 4) != 0) begin
			live = pool.pick_busy();
			if (live >= 0)
				r.chunk_index = IDX_W'(live);
		end
		return r;
	endfunction

	// Send one request after a random gap; the first 50 of every 200 go back to back.
	task automatic send_request(req_t r);
		int gap;
		gap = ((sent_n % 200) < 50) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		pool.note_request(r);
		sent_n = sent_n + 1;
	endtask

	// Stop sending and wait until every predicted response has arrived.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pool.pending_rsp.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pool_base(logic [ADDR_W-1:0] value);
		wait_for_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		pool.base   = value;
		base_writes = base_writes + 1;
	endtask

	initial begin
		int n;
		pool        = new();
		sent_n      = 0;
		cycles      = 0;
		stall_left  = 0;
		base_writes = 0;
		arst_n      = 1'b1;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b1;
		// Assert reset after time zero so the falling edge is always seen.
		#1 arst_n   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: size limits, double free, free of idle chunks, reuse order.
		send_request(make_req(OP_ALLOC, 32'd0, 10'd0));
		send_request(make_req(OP_ALLOC, 32'd129, 10'd5));
		send_request(make_req(OP_ALLOC, 32'hFFFF_FFFF, 10'h3FF));
		send_request(make_req(OP_ALLOC, 32'h8000_0000, 10'd0));
		send_request(make_req(OP_ALLOC, 32'd1, 10'h3FF));
		send_request(make_req(OP_ALLOC, 32'd128, 10'd0));
		send_request(make_req(OP_FREE, 32'hFFFF_FFFF, 10'd0));
		send_request(make_req(OP_FREE, 32'd0, 10'd0));
		send_request(make_req(OP_FREE, 32'd64, 10'h3FF));
		send_request(make_req(OP_FREE, 32'd1, 10'd2));
		send_request(make_req(OP_ALLOC, 32'd64, 10'd0));
		send_request(make_req(OP_ALLOC, 32'd127, 10'd0));
		send_request(make_req(OP_FREE, 32'd0, 10'd1));
		send_request(make_req(OP_FREE, 32'd0, 10'd2));
		send_request(make_req(OP_FREE, 32'd0, 10'd1));
		send_request(make_req(OP_ALLOC, 32'd2, 10'd0));

		// Top pool base: addresses wrap past the end of the address space.
		write_pool_base(32'hFFFF_FFFF);
		for (n = 0; n < 300; n++)
			send_request(random_request(80));

		// Random pool base: allocate until the pool runs dry, then keep pushing.
		write_pool_base($urandom());
		n = 0;
		while (n < 40 && sent_n < 2200) begin
			send_request(random_request(95));
			if (pool.avail == 0)
				n = n + 1;
		end

		// Zero pool base: mostly frees, refilling the queue in scrambled order.
		write_pool_base(32'h0000_0000);
		for (n = 0; n < 250; n++)
			send_request(random_request(25));

		wait_for_idle();
		repeat (10) @(posedge clk);
		$display("Sent %0d requests under %0d pool base settings; checked %0d responses.",
			sent_n, base_writes + 1, pool.checked);
		$display("Status mix: ok %0d, size refused %0d, out of memory %0d, not in use %0d.",
			pool.status_seen[ST_OK], pool.status_seen[ST_SIZE],
			pool.status_seen[ST_NOMEM], pool.status_seen[ST_NOTUSED]);
		if (pool.mismatches == 0 && pool.pending_rsp.size() == 0) begin
			$display("tb_fixed_chunk_allocator: clean");
		end else begin
			$display("tb_fixed_chunk_allocator: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fca_pkg.sv
rtl/fixed_chunk_allocator.sv
test/tb_fixed_chunk_allocator.sv
